// ===== src/mcfsa_pkg.sv =====
// shared constants, codes and types of the frame set aligner
package mcfsa_pkg;

    localparam int STORE_DEPTH_DEF = 64;
    localparam int MAX_CAMS_DEF    = 8;
    localparam int TIME_BITS_DEF   = 48;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int CAM_BITS     = 3;
    localparam int CAM_SLOTS    = 1 << CAM_BITS;
    localparam int NCAM_BITS    = 4;
    localparam int CFG_BITS     = 24;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [NCAM_BITS-1:0] NUM_CAMS_RST  = 4'd4;
    localparam logic [CFG_BITS-1:0]  WINDOW_RST    = 24'd20000;
    localparam logic [CFG_BITS-1:0]  FRAME_INT_RST = 24'd100000;
    localparam logic [CFG_BITS-1:0]  MISSED_RST    = 24'd150000;
    localparam logic [CFG_BITS-1:0]  DUMP_RST      = 24'd1000000;
    localparam logic [CFG_BITS-1:0]  HALF_RST      = 24'd51000;

    localparam logic RES_MEMBER = 1'b0;
    localparam logic RES_DROP   = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NUM_CAMS,
        REG_ALIGN_WINDOW,
        REG_FRAME_INTERVAL,
        REG_MISSED_INTERVAL,
        REG_DUMP_INTERVAL,
        REG_SEARCH_HALF
    } cfg_reg_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_INS_RD,
        OP_INS_WR,
        OP_INS_NEW,
        OP_DECIDE,
        OP_SPAN,
        OP_SC_INIT_C,
        OP_SC_INIT_D,
        OP_LRD,
        OP_LLD,
        OP_TRD,
        OP_TLD,
        OP_HAVE,
        OP_EVAL,
        OP_NEXT,
        OP_CUT_TGT,
        OP_MB_INIT,
        OP_MB_RD,
        OP_MB_TST,
        OP_MB_FIN,
        OP_PG_INIT,
        OP_PG_RD,
        OP_PG_INC,
        OP_SH_INIT,
        OP_SH_RD,
        OP_SH_WR,
        OP_SH_FIN,
        OP_OUT_DROP,
        OP_OUT_CAM,
        OP_CINC
    } op_t;

    typedef struct packed {
        logic full;
        logic ptr_zero;
        logic ptr_end;
        logic ins_hit;
        logic mode_dump;
        logic mode_miss;
        logic lead_end;
        logic below_lo;
        logic above_hi;
        logic have;
        logic win_over;
        logic cnt_eq;
        logic found;
        logic pg_le;
        logic drop;
        logic out_full;
        logic seen_c;
        logic c_end;
    } stat_t;

endpackage

// ===== src/mcfsa_ifs.sv =====
// request channels of the frame set aligner
interface mcfsa_frame_if
    import mcfsa_pkg::*;
#(
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [CAM_BITS-1:0]    cam_index;
    logic [TIME_BITS-1:0]   frame_time_us;
    logic [HANDLE_BITS-1:0] frame_handle;

    modport source (output valid, cam_index, frame_time_us, frame_handle, input ready);
    modport sink (input valid, cam_index, frame_time_us, frame_handle, output ready);
endinterface

interface mcfsa_res_if
    import mcfsa_pkg::*;
#(
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   status;
    logic [CAM_BITS-1:0]    out_cam;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [TIME_BITS-1:0]   set_time_us;
    logic                   last;

    modport source (output valid, status, out_cam, out_handle, set_time_us, last,
                    input ready);
    modport sink (input valid, status, out_cam, out_handle, set_time_us, last,
                  output ready);
endinterface

interface mcfsa_cfg_if
    import mcfsa_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/mcfsa_datapath.sv =====
// sorted frame store, window search, purge and result registers
module mcfsa_datapath
    import mcfsa_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_CAMS    = MAX_CAMS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  op_t                    op,
    output stat_t                  stat,
    input  logic [CAM_BITS-1:0]    cam_index,
    input  logic [TIME_BITS-1:0]   frame_time_us,
    input  logic [HANDLE_BITS-1:0] frame_handle,
    mcfsa_cfg_if.sink              cfg,
    mcfsa_res_if.source            result
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int ENT_W = TIME_BITS + CAM_BITS + HANDLE_BITS;
    localparam int CMP_W = (CNT_W > NCAM_BITS) ? CNT_W : NCAM_BITS;
    localparam logic [CNT_W-1:0]     DEPTH_CNT = CNT_W'(STORE_DEPTH);
    localparam logic [TIME_BITS-1:0] TMAX      = '1;

    // configuration
    logic [NCAM_BITS-1:0] ncam_reg;
    logic [CFG_BITS-1:0]  win_us_reg, frm_us_reg, mis_us_reg, dmp_us_reg, half_us_reg;

    // store
    logic [ENT_W-1:0] mem [STORE_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             wr_en;

    // control state
    logic [CNT_W-1:0]     count_reg, ptr_reg, dst_reg, lead_reg, trail_reg, best_reg;
    logic                 drop_reg, mode_dump_reg, mode_miss_reg, have_reg, found_reg;
    logic [CAM_SLOTS-1:0] seen_reg;
    logic [CAM_BITS-1:0]  c_reg;
    logic                 out_valid_reg;
    logic [TIME_BITS-1:0] ls_reg;

    // payload state
    logic [CAM_BITS-1:0]    cam_reg;
    logic [TIME_BITS-1:0]   t_reg, t_lead_reg, t_trail_reg, a_reg, b_reg;
    logic [TIME_BITS-1:0]   tgt_reg, lo_reg, hi_reg, cut_reg;
    logic [TIME_BITS:0]     ab_sum_reg;
    logic [HANDLE_BITS-1:0] h_reg;
    logic [HANDLE_BITS-1:0] hand_reg [CAM_SLOTS];
    logic                   o_status_reg, o_last_reg;
    logic [CAM_BITS-1:0]    o_cam_reg;
    logic [HANDLE_BITS-1:0] o_hand_reg;
    logic [TIME_BITS-1:0]   o_time_reg;

    // derived values
    logic [TIME_BITS-1:0]   rd_time, dt, dump_cut, tgt_next, lo_next, hi_next, cut_set;
    logic [CAM_BITS-1:0]    rd_cam;
    logic [HANDLE_BITS-1:0] rd_hand;
    logic [TIME_BITS:0]     tgt_sum, hi_sum, two_t, dev, half3;
    logic [TIME_BITS+1:0]   sum3;
    logic [CNT_W-1:0]       ptr_m1, trail_p1, cnt;
    logic [CAM_SLOTS-1:0]   seen_hi;
    logic                   ins_hit, t_gt, over_d, over_m, in_set, cam_ok;
    logic [ENT_W-1:0]       new_ent;

    assign rd_time = rd_data_reg[ENT_W-1 -: TIME_BITS];
    assign rd_cam  = rd_data_reg[HANDLE_BITS +: CAM_BITS];
    assign rd_hand = rd_data_reg[HANDLE_BITS-1:0];
    assign new_ent = {t_reg, cam_reg, h_reg};

    assign ptr_m1   = ptr_reg - 1'b1;
    assign trail_p1 = trail_reg + 1'b1;
    assign cnt      = lead_reg - trail_reg + 1'b1;

    assign ins_hit  = rd_time <= t_reg;
    assign t_gt     = t_reg > ls_reg;
    assign dt       = t_reg - ls_reg;
    assign over_d   = dt > TIME_BITS'(dmp_us_reg);
    assign over_m   = dt > TIME_BITS'(mis_us_reg);
    assign dump_cut = (t_reg >= TIME_BITS'(frm_us_reg)) ? t_reg - TIME_BITS'(frm_us_reg) : '0;
    assign tgt_sum  = {1'b0, ls_reg} + (TIME_BITS+1)'(frm_us_reg);
    assign tgt_next = tgt_sum[TIME_BITS] ? TMAX : tgt_sum[TIME_BITS-1:0];
    assign lo_next  = (tgt_reg >= TIME_BITS'(half_us_reg)) ?
                      tgt_reg - TIME_BITS'(half_us_reg) : '0;
    assign hi_sum   = {1'b0, tgt_reg} + (TIME_BITS+1)'(half_us_reg);
    assign hi_next  = hi_sum[TIME_BITS] ? TMAX : hi_sum[TIME_BITS-1:0];

    // |2t - a - b| <= window
    assign two_t  = {rd_time, 1'b0};
    assign dev    = (two_t >= ab_sum_reg) ? two_t - ab_sum_reg : ab_sum_reg - two_t;
    assign in_set = dev <= (TIME_BITS+1)'(win_us_reg);
    assign cam_ok = int'(rd_cam) < MAX_CAMS;

    // floor((a + b + window) / 2), saturated
    assign sum3    = (TIME_BITS+2)'(a_reg) + (TIME_BITS+2)'(b_reg)
                   + (TIME_BITS+2)'(win_us_reg);
    assign half3   = sum3[TIME_BITS+1:1];
    assign cut_set = half3[TIME_BITS] ? TMAX : half3[TIME_BITS-1:0];

    assign seen_hi = seen_reg >> c_reg;

    always_comb
    begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = ptr_reg[IDX_W-1:0];
        wr_data = new_ent;
        case (op)
            OP_INS_RD:  rd_addr = ptr_m1[IDX_W-1:0];
            OP_INS_WR:
            begin
                wr_en = 1'b1;
                if (!ins_hit)
                begin
                    wr_data = rd_data_reg;
                end
            end
            OP_INS_NEW: wr_en = 1'b1;
            OP_PG_RD, OP_SH_RD, OP_MB_RD: rd_addr = ptr_reg[IDX_W-1:0];
            OP_SH_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = dst_reg[IDX_W-1:0];
                wr_data = rd_data_reg;
            end
            OP_LRD: rd_addr = lead_reg[IDX_W-1:0];
            OP_TRD: rd_addr = trail_p1[IDX_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncam_reg      <= NUM_CAMS_RST;
            win_us_reg    <= WINDOW_RST;
            frm_us_reg    <= FRAME_INT_RST;
            mis_us_reg    <= MISSED_RST;
            dmp_us_reg    <= DUMP_RST;
            half_us_reg   <= HALF_RST;
            count_reg     <= '0;
            ls_reg        <= '0;
            ptr_reg       <= '0;
            dst_reg       <= '0;
            lead_reg      <= '0;
            trail_reg     <= '0;
            best_reg      <= '0;
            drop_reg      <= 1'b0;
            mode_dump_reg <= 1'b0;
            mode_miss_reg <= 1'b0;
            have_reg      <= 1'b0;
            found_reg     <= 1'b0;
            seen_reg      <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_NUM_CAMS:        ncam_reg    <= cfg.data[NCAM_BITS-1:0];
                    REG_ALIGN_WINDOW:    win_us_reg  <= cfg.data;
                    REG_FRAME_INTERVAL:  frm_us_reg  <= cfg.data;
                    REG_MISSED_INTERVAL: mis_us_reg  <= cfg.data;
                    REG_DUMP_INTERVAL:   dmp_us_reg  <= cfg.data;
                    REG_SEARCH_HALF:     half_us_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                OP_LOAD:
                begin
                    drop_reg  <= count_reg == DEPTH_CNT;
                    ptr_reg   <= count_reg;
                    found_reg <= 1'b0;
                    seen_reg  <= '0;
                    c_reg     <= '0;
                end
                OP_INS_WR:
                begin
                    if (ins_hit)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    else
                    begin
                        ptr_reg <= ptr_m1;
                    end
                end
                OP_INS_NEW: count_reg <= count_reg + 1'b1;
                OP_DECIDE:
                begin
                    mode_dump_reg <= t_gt && over_d;
                    mode_miss_reg <= t_gt && !over_d && over_m;
                end
                OP_SC_INIT_C:
                begin
                    lead_reg  <= CNT_W'(1);
                    trail_reg <= '0;
                end
                OP_SC_INIT_D:
                begin
                    lead_reg <= '0;
                    best_reg <= '0;
                    have_reg <= 1'b0;
                end
                OP_TRD:  trail_reg <= trail_p1;
                OP_HAVE:
                begin
                    trail_reg <= lead_reg;
                    have_reg  <= 1'b1;
                end
                OP_EVAL:
                begin
                    if (!mode_miss_reg && (CMP_W'(cnt) == CMP_W'(ncam_reg)))
                    begin
                        found_reg <= 1'b1;
                    end
                    if (mode_miss_reg && (cnt > best_reg))
                    begin
                        best_reg  <= cnt;
                        found_reg <= 1'b1;
                    end
                end
                OP_NEXT: lead_reg <= lead_reg + 1'b1;
                OP_MB_INIT:
                begin
                    ptr_reg  <= '0;
                    seen_reg <= '0;
                end
                OP_MB_TST:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (in_set && cam_ok && !seen_reg[rd_cam])
                    begin
                        seen_reg[rd_cam] <= 1'b1;
                    end
                end
                OP_MB_FIN:
                begin
                    // a drop result takes one of the eight result slots
                    if (drop_reg && (&seen_reg))
                    begin
                        seen_reg[CAM_SLOTS-1] <= 1'b0;
                    end
                end
                OP_PG_INIT: ptr_reg <= '0;
                OP_PG_INC:  ptr_reg <= ptr_reg + 1'b1;
                OP_SH_INIT: dst_reg <= '0;
                OP_SH_WR:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    dst_reg <= dst_reg + 1'b1;
                end
                OP_SH_FIN:
                begin
                    count_reg <= dst_reg;
                    ls_reg    <= cut_reg;
                end
                OP_OUT_DROP: out_valid_reg <= 1'b1;
                OP_OUT_CAM:
                begin
                    out_valid_reg <= 1'b1;
                    c_reg         <= c_reg + 1'b1;
                end
                OP_CINC: c_reg <= c_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cam_reg <= cam_index;
                t_reg   <= frame_time_us;
                h_reg   <= frame_handle;
            end
            OP_DECIDE:
            begin
                tgt_reg <= tgt_next;
                cut_reg <= dump_cut;
            end
            OP_SPAN:
            begin
                lo_reg <= lo_next;
                hi_reg <= hi_next;
            end
            OP_LLD: t_lead_reg  <= rd_time;
            OP_TLD: t_trail_reg <= rd_time;
            OP_HAVE: t_trail_reg <= t_lead_reg;
            OP_EVAL:
            begin
                if ((!mode_miss_reg && (CMP_W'(cnt) == CMP_W'(ncam_reg)))
                    || (mode_miss_reg && (cnt > best_reg)))
                begin
                    a_reg <= t_trail_reg;
                    b_reg <= t_lead_reg;
                end
            end
            OP_CUT_TGT: cut_reg <= tgt_reg;
            OP_MB_INIT:
            begin
                ab_sum_reg <= (TIME_BITS+1)'(a_reg) + (TIME_BITS+1)'(b_reg);
                cut_reg    <= cut_set;
            end
            OP_MB_TST:
            begin
                if (in_set && cam_ok && !seen_reg[rd_cam])
                begin
                    hand_reg[rd_cam] <= rd_hand;
                end
            end
            OP_OUT_DROP:
            begin
                o_status_reg <= RES_DROP;
                o_cam_reg    <= cam_reg;
                o_hand_reg   <= h_reg;
                o_time_reg   <= '0;
                o_last_reg   <= seen_reg == '0;
            end
            OP_OUT_CAM:
            begin
                o_status_reg <= RES_MEMBER;
                o_cam_reg    <= c_reg;
                o_hand_reg   <= hand_reg[c_reg];
                o_time_reg   <= ab_sum_reg[TIME_BITS:1];
                o_last_reg   <= seen_hi[CAM_SLOTS-1:1] == '0;
            end
            default: ;
        endcase
    end

    assign cfg.ready          = 1'b1;
    assign result.valid       = out_valid_reg;
    assign result.status      = o_status_reg;
    assign result.out_cam     = o_cam_reg;
    assign result.out_handle  = o_hand_reg;
    assign result.set_time_us = o_time_reg;
    assign result.last        = o_last_reg;

    assign stat.full      = count_reg == DEPTH_CNT;
    assign stat.ptr_zero  = ptr_reg == '0;
    assign stat.ptr_end   = ptr_reg == count_reg;
    assign stat.ins_hit   = ins_hit;
    assign stat.mode_dump = mode_dump_reg;
    assign stat.mode_miss = mode_miss_reg;
    assign stat.lead_end  = lead_reg >= count_reg;
    assign stat.below_lo  = t_lead_reg < lo_reg;
    assign stat.above_hi  = t_lead_reg > hi_reg;
    assign stat.have      = have_reg;
    assign stat.win_over  = (t_lead_reg - t_trail_reg) > TIME_BITS'(win_us_reg);
    assign stat.cnt_eq    = CMP_W'(cnt) == CMP_W'(ncam_reg);
    assign stat.found     = found_reg;
    assign stat.pg_le     = rd_time <= cut_reg;
    assign stat.drop      = drop_reg;
    assign stat.out_full  = out_valid_reg;
    assign stat.seen_c    = seen_reg[c_reg];
    assign stat.c_end     = c_reg == '1;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("store count beyond depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_INS_NEW |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the store");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_OUT_DROP || op == OP_OUT_CAM) |-> !out_valid_reg)
        else $error("pending result overwritten");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_SH_FIN |-> dst_reg <= count_reg)
        else $error("purge grew the store");
`endif

endmodule

// ===== src/mcfsa_ctrl.sv =====
// sequencer of insert, search, member collection, purge and result output
module mcfsa_ctrl
    import mcfsa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  frame_valid,
    output logic  frame_ready,
    input  stat_t stat,
    output op_t   op
);

    typedef enum logic [5:0] {
        S_IDLE, S_INS_CHK, S_INS_RD, S_INS_WR, S_INS_NEW,
        S_DEC, S_SPAN, S_SCC, S_I_LD, S_SCD,
        S_L_CHK, S_L_RD, S_L_LD, S_TST, S_HAVE, S_WIN, S_T_RD, S_T_LD, S_NEXT, S_DONE,
        S_CUT_TGT, S_MB_INIT, S_MB_CHK, S_MB_RD, S_MB_TST, S_MB_FIN,
        S_PG_INIT, S_PG_CHK, S_PG_RD, S_PG_TST,
        S_SH_INIT, S_SH_CHK, S_SH_RD, S_SH_WR, S_SH_FIN,
        S_EM_DROP, S_EM_CAM
    } state_t;

    state_t state_reg;

    assign frame_ready = state_reg == S_IDLE;

    always_comb
    begin
        op = OP_IDLE;
        case (state_reg)
            S_IDLE:    if (frame_valid) op = OP_LOAD;
            S_INS_RD:  op = OP_INS_RD;
            S_INS_WR:  op = OP_INS_WR;
            S_INS_NEW: op = OP_INS_NEW;
            S_DEC:     op = OP_DECIDE;
            S_SPAN:    op = OP_SPAN;
            S_SCC:     op = OP_SC_INIT_C;
            S_I_LD:    op = OP_TLD;
            S_SCD:     op = OP_SC_INIT_D;
            S_L_RD:    op = OP_LRD;
            S_L_LD:    op = OP_LLD;
            S_HAVE:    op = OP_HAVE;
            S_WIN:     if (!stat.win_over) op = OP_EVAL;
            S_T_RD:    op = OP_TRD;
            S_T_LD:    op = OP_TLD;
            S_NEXT:    op = OP_NEXT;
            S_CUT_TGT: op = OP_CUT_TGT;
            S_MB_INIT: op = OP_MB_INIT;
            S_MB_RD:   op = OP_MB_RD;
            S_MB_TST:  op = OP_MB_TST;
            S_MB_FIN:  op = OP_MB_FIN;
            S_PG_INIT: op = OP_PG_INIT;
            S_PG_RD:   op = OP_PG_RD;
            S_PG_TST:  if (stat.pg_le) op = OP_PG_INC;
            S_SH_INIT: op = OP_SH_INIT;
            S_SH_RD:   op = OP_SH_RD;
            S_SH_WR:   op = OP_SH_WR;
            S_SH_FIN:  op = OP_SH_FIN;
            S_EM_DROP: if (stat.drop && !stat.out_full) op = OP_OUT_DROP;
            S_EM_CAM:
            begin
                if (!stat.seen_c)
                begin
                    op = OP_CINC;
                end
                else if (!stat.out_full)
                begin
                    op = OP_OUT_CAM;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (frame_valid)
                    begin
                        state_reg <= stat.full ? S_DEC : S_INS_CHK;
                    end
                end
                S_INS_CHK: state_reg <= stat.ptr_zero ? S_INS_NEW : S_INS_RD;
                S_INS_RD:  state_reg <= S_INS_WR;
                S_INS_WR:  state_reg <= stat.ins_hit ? S_DEC : S_INS_CHK;
                S_INS_NEW: state_reg <= S_DEC;
                S_DEC:     state_reg <= S_SPAN;
                S_SPAN:
                begin
                    if (stat.mode_dump)
                    begin
                        state_reg <= S_PG_INIT;
                    end
                    else if (stat.mode_miss)
                    begin
                        state_reg <= S_SCD;
                    end
                    else
                    begin
                        state_reg <= S_SCC;
                    end
                end
                S_SCC:  state_reg <= S_I_LD;
                S_I_LD: state_reg <= S_L_CHK;
                S_SCD:  state_reg <= S_L_CHK;
                S_L_CHK: state_reg <= stat.lead_end ? S_DONE : S_L_RD;
                S_L_RD:  state_reg <= S_L_LD;
                S_L_LD:  state_reg <= S_TST;
                S_TST:
                begin
                    if (!stat.mode_miss)
                    begin
                        state_reg <= S_WIN;
                    end
                    else if (stat.below_lo)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else if (stat.above_hi)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (!stat.have)
                    begin
                        state_reg <= S_HAVE;
                    end
                    else
                    begin
                        state_reg <= S_WIN;
                    end
                end
                S_HAVE: state_reg <= S_WIN;
                S_WIN:
                begin
                    if (stat.win_over)
                    begin
                        state_reg <= S_T_RD;
                    end
                    else if (!stat.mode_miss && stat.cnt_eq)
                    begin
                        state_reg <= S_MB_INIT;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_T_RD: state_reg <= S_T_LD;
                S_T_LD: state_reg <= S_WIN;
                S_NEXT: state_reg <= S_L_CHK;
                S_DONE:
                begin
                    if (stat.found)
                    begin
                        state_reg <= S_MB_INIT;
                    end
                    else if (stat.mode_miss)
                    begin
                        state_reg <= S_CUT_TGT;
                    end
                    else
                    begin
                        state_reg <= S_EM_DROP;
                    end
                end
                S_CUT_TGT: state_reg <= S_PG_INIT;
                S_MB_INIT: state_reg <= S_MB_CHK;
                S_MB_CHK:  state_reg <= stat.ptr_end ? S_MB_FIN : S_MB_RD;
                S_MB_RD:   state_reg <= S_MB_TST;
                S_MB_TST:  state_reg <= S_MB_CHK;
                S_MB_FIN:  state_reg <= S_PG_INIT;
                S_PG_INIT: state_reg <= S_PG_CHK;
                S_PG_CHK:  state_reg <= stat.ptr_end ? S_SH_INIT : S_PG_RD;
                S_PG_RD:   state_reg <= S_PG_TST;
                S_PG_TST:  state_reg <= stat.pg_le ? S_PG_CHK : S_SH_INIT;
                S_SH_INIT: state_reg <= S_SH_CHK;
                S_SH_CHK:  state_reg <= stat.ptr_end ? S_SH_FIN : S_SH_RD;
                S_SH_RD:   state_reg <= S_SH_WR;
                S_SH_WR:   state_reg <= S_SH_CHK;
                S_SH_FIN:  state_reg <= S_EM_DROP;
                S_EM_DROP:
                begin
                    if (!stat.drop || !stat.out_full)
                    begin
                        state_reg <= S_EM_CAM;
                    end
                end
                S_EM_CAM:
                begin
                    if ((!stat.seen_c || !stat.out_full) && stat.c_end)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/multi_camera_frame_set_aligner.sv =====
// top level of the multi-camera frame set aligner
// channels: frame takes one frame arrival per request (camera, capture time, handle);
// result gives the requests caused by it: an optional store-full drop request first,
// then one request per camera of a published set in ascending camera order,
// the final one flagged by last; cfg writes one of six registers by index,
// always ready; cfg is to be written only while the block is idle, the block itself does not enforce it.
// one frame at a time: frame.ready is high only while the sequencer idles.
// each pass over the store goes one entry at a time through the single read port of the
// store memory: moving entries on insert, the window search with its trail steps,
// member collection and the purge (count and shift together).
// results leave through one output register; a frame whose results are all
// loaded lets the next frame in while its last result still waits.
// when the receiver stalls, the sequencer holds before loading the next result.
// reset empties the store, clears the sync time and loads the register defaults;
// the store contents need no clearing.
module multi_camera_frame_set_aligner
    import mcfsa_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_CAMS    = MAX_CAMS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    mcfsa_frame_if.sink  frame,
    mcfsa_res_if.source  result,
    mcfsa_cfg_if.sink    cfg
);

    op_t   op;
    stat_t stat;
    logic  frame_ready;

    mcfsa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame.valid),
        .frame_ready (frame_ready),
        .stat        (stat),
        .op          (op)
    );

    assign frame.ready = frame_ready;

    mcfsa_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_CAMS    (MAX_CAMS),
        .TIME_BITS   (TIME_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .stat          (stat),
        .cam_index     (frame.cam_index),
        .frame_time_us (frame.frame_time_us),
        .frame_handle  (frame.frame_handle),
        .cfg           (cfg),
        .result        (result)
    );

endmodule
